>>> rtl/odci_pkg.sv
package odci_pkg;

  // Reciprocal of d, ceil(2^RCP_SHIFT / d), exact for dividends below 2^12
  localparam int unsigned RCP_W     = 17;
  localparam int unsigned RCP_SHIFT = 16;

  localparam logic [RCP_W-1:0] RECIP [16] = '{
    17'd0,    17'd65536, 17'd32768, 17'd21846,
    17'd16384, 17'd13108, 17'd10923, 17'd9363,
    17'd8192, 17'd7282,  17'd6554,  17'd5958,
    17'd5462, 17'd5042,  17'd4682,  17'd4370
  };

  // 4x4 magic square, indexed {col[1:0], row[1:0]}
  localparam logic [3:0] MAGIC [16] = '{
    4'd0,  4'd14, 4'd3,  4'd13,
    4'd11, 4'd5,  4'd8,  4'd6,
    4'd12, 4'd2,  4'd15, 4'd1,
    4'd7,  4'd9,  4'd4,  4'd10
  };

  // floor(x / 255) = (x * 0x8081) >> 23 for x < 2^16
  localparam logic [15:0] DIV255_MUL   = 16'h8081;
  localparam int unsigned DIV255_SHIFT = 23;

  localparam int unsigned THR_W = 9;

  typedef enum logic [1:0] {
    CFG_LEVELS = 2'd0,
    CFG_MONO   = 2'd1
  } cfg_reg_e;

endpackage

>>> rtl/odci_thresh.sv
module odci_thresh
  import odci_pkg::*;
#(
  parameter int unsigned DW = 4
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [3:0]             col_i,
  input  logic [3:0]             row_i,
  input  logic [DW-1:0]          d_i,
  input  logic [RCP_W-1:0]       recip_i,
  output logic [THR_W-1:0]       t_o
);

  logic [3:0]             a, b;
  logic [7:0]             k;
  logic [7:0]             span;
  logic [17:0]            num;
  logic [8:0]             nh_d, nh_q;
  logic [9+RCP_W-1:0]     tp;
  logic [THR_W-1:0]       t2_d, t2_q, t3_q;

  // k = 16*A + B, threshold numerator 2*k*(255-d) + 256*d
  always_comb begin
    a    = MAGIC[{col_i[1:0], row_i[1:0]}];
    b    = MAGIC[{col_i[3:2], row_i[3:2]}];
    k    = {a, b};
    span = 8'd255 - 8'(d_i);
    num  = 18'({k, 1'b0}) * 18'(span) + (18'(d_i) << 8);
    nh_d = num[17:9];
  end

  assign tp   = 26'(nh_q) * 26'(recip_i);
  assign t2_d = tp[RCP_SHIFT +: THR_W];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nh_q <= nh_d;
      t2_q <= t2_d;
      t3_q <= t2_q;
    end
  end

  assign t_o = t3_q;

endmodule

>>> rtl/odci_chan.sv
module odci_chan
  import odci_pkg::*;
#(
  parameter int unsigned DW = 4
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [7:0]         v_i,
  input  logic [DW-1:0]      d_i,
  input  logic [RCP_W-1:0]   recip_i,
  input  logic [THR_W-1:0]   t_i,
  output logic [DW-1:0]      ch_o
);

  localparam int unsigned XW = 8 + DW;

  logic [XW-1:0]          x1_d, x1_q;
  logic [7:0]             v1_q, v2_q;
  logic                   full1_q, full2_q;
  logic [XW+15:0]         qp;
  logic [DW-1:0]          q2_d, q2_q, q3_q;
  logic [XW-1:0]          q255;
  logic [XW+RCP_W-1:0]    rp;
  logic [7:0]             r;
  logic [7:0]             m3_d, m3_q;
  logic                   raise;
  logic [DW-1:0]          ch_d, ch_q;

  assign x1_d = XW'(v_i) * XW'(d_i);

  assign qp   = (XW+16)'(x1_q) * (XW+16)'(DIV255_MUL);
  assign q2_d = qp[DIV255_SHIFT +: DW];

  // r = floor(255*q / d); full intensity never rises
  assign q255 = (XW'(q2_q) << 8) - XW'(q2_q);
  assign rp   = (XW+RCP_W)'(q255) * (XW+RCP_W)'(recip_i);
  assign r    = rp[RCP_SHIFT +: 8];
  assign m3_d = full2_q ? 8'd0 : v2_q - r;

  assign raise = {1'b0, m3_q} > t_i;
  assign ch_d  = q3_q + DW'(raise);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q    <= x1_d;
      v1_q    <= v_i;
      full1_q <= (v_i == 8'd255);
      q2_q    <= q2_d;
      v2_q    <= v1_q;
      full2_q <= full1_q;
      m3_q    <= m3_d;
      q3_q    <= q2_q;
      ch_q    <= ch_d;
    end
  end

  assign ch_o = ch_q;

endmodule

>>> rtl/ordered_dither_color_index.sv
// Ordered 16x16 magic-square dither of one pixel to a colormap index.
// Registered pipeline from input accept to output valid: product, quotient, remainder, channel and index stages.
// Throughput: one word per cycle; a stall on the output freezes the whole pipe.
// Reset (async, active low): pipe empty, levels = min(6, MAX_LEVELS), mono_mode = 0.
// Per-level reciprocal and levels^2 are refreshed on each levels write.
module ordered_dither_color_index
  import odci_pkg::*;
#(
  parameter int unsigned MAX_LEVELS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] x_pos_i,
  input  logic [15:0] y_pos_i,
  input  logic [7:0]  red_or_gray_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] map_index_o
);

  localparam int unsigned DW     = $clog2(MAX_LEVELS);
  localparam int unsigned LW     = $clog2(MAX_LEVELS + 1);
  localparam int unsigned SW     = DW + 2 * LW + 1;
  localparam int unsigned RST_LV = (MAX_LEVELS < 6) ? MAX_LEVELS : 6;
  localparam logic [4:0]  MAX_LV = 5'(MAX_LEVELS);

  logic [LW-1:0]      lv_q;
  logic [2*LW-1:0]    lv2_q;
  logic [DW-1:0]      d_q;
  logic [RCP_W-1:0]   recip_q;
  logic               mono_q;

  logic [4:0]         lv_new;
  logic [4:0]         d_new;

  logic               en;
  logic [4:0]         vld_q;
  logic [THR_W-1:0]   t;
  logic [DW-1:0]      ch_r, ch_g, ch_b;
  logic [SW-1:0]      idx;
  logic [11:0]        idx_q;

  // Config
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (cfg_data_i < 5'd2) begin
      lv_new = 5'd2;
    end else if (cfg_data_i > MAX_LV) begin
      lv_new = MAX_LV;
    end else begin
      lv_new = cfg_data_i;
    end
    d_new = lv_new - 5'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lv_q    <= LW'(RST_LV);
      lv2_q   <= (2*LW)'(RST_LV * RST_LV);
      d_q     <= DW'(RST_LV - 1);
      recip_q <= RECIP[4'(RST_LV - 1)];
      mono_q  <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_LEVELS: begin
          lv_q    <= LW'(lv_new);
          lv2_q   <= (2*LW)'(lv_new) * (2*LW)'(lv_new);
          d_q     <= DW'(d_new);
          recip_q <= RECIP[d_new[3:0]];
        end
        CFG_MONO: begin
          mono_q <= cfg_data_i[0];
        end
        default: ;
      endcase
    end
  end

  // Pipe control: all stages advance together unless the output word is stuck
  assign en         = ~vld_q[4] | out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[3:0], in_valid_i};
    end
  end

  odci_thresh #(.DW(DW)) u_thresh (
    .clk_i   (clk_i),
    .en_i    (en),
    .col_i   (x_pos_i[3:0]),
    .row_i   (y_pos_i[3:0]),
    .d_i     (d_q),
    .recip_i (recip_q),
    .t_o     (t)
  );

  odci_chan #(.DW(DW)) u_chan_r (
    .clk_i   (clk_i),
    .en_i    (en),
    .v_i     (red_or_gray_i),
    .d_i     (d_q),
    .recip_i (recip_q),
    .t_i     (t),
    .ch_o    (ch_r)
  );

  odci_chan #(.DW(DW)) u_chan_g (
    .clk_i   (clk_i),
    .en_i    (en),
    .v_i     (green_i),
    .d_i     (d_q),
    .recip_i (recip_q),
    .t_i     (t),
    .ch_o    (ch_g)
  );

  odci_chan #(.DW(DW)) u_chan_b (
    .clk_i   (clk_i),
    .en_i    (en),
    .v_i     (blue_i),
    .d_i     (d_q),
    .recip_i (recip_q),
    .t_i     (t),
    .ch_o    (ch_b)
  );

  // Combine channels into colormap index; mono mode uses the red/gray channel alone
  always_comb begin
    if (mono_q) begin
      idx = SW'(ch_r);
    end else begin
      idx = SW'(ch_r) + SW'(ch_g) * SW'(lv_q) + SW'(ch_b) * SW'(lv2_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      idx_q <= 12'(idx);
    end
  end

  assign out_valid_o = vld_q[4];
  assign map_index_o = idx_q;

endmodule
